// ----- rtl/md5_pin_candidate_matcher_macros.svh -----
// assertion macros shared by the matcher checker
`ifndef MD5_PIN_CANDIDATE_MATCHER_MACROS_SVH
`define MD5_PIN_CANDIDATE_MATCHER_MACROS_SVH

// clocked assertion, off while reset is high
`define MPCM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion that also holds through reset
`define MPCM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/mpcm_pkg.sv -----
// shared types, constants and md5 round tables for the pin matcher
package mpcm_pkg;

  localparam int PinDigitsDef = 8;
  localparam int CandW        = 27;
  localparam int AddrW        = 5;
  localparam int Rounds       = 64;
  localparam logic [5:0] PrefixReset = 6'd32;

  typedef enum logic [1:0] {
    REG_TGT_HIGH = 2'd0,
    REG_TGT_LOW  = 2'd1,
    REG_PREFIX   = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
  } md_state_t;

  typedef logic [15:0][31:0] md_block_t;

  localparam md_state_t MdIv = '{a: 32'h67452301, b: 32'hefcdab89,
                                 c: 32'h98badcfe, d: 32'h10325476};

  // additive round constant
  function automatic logic [31:0] md_k(input int i);
    logic [31:0] k;
    case (i)
      0: k = 32'hd76aa478;  1: k = 32'he8c7b756;  2: k = 32'h242070db;  3: k = 32'hc1bdceee;
      4: k = 32'hf57c0faf;  5: k = 32'h4787c62a;  6: k = 32'ha8304613;  7: k = 32'hfd469501;
      8: k = 32'h698098d8;  9: k = 32'h8b44f7af; 10: k = 32'hffff5bb1; 11: k = 32'h895cd7be;
      12: k = 32'h6b901122; 13: k = 32'hfd987193; 14: k = 32'ha679438e; 15: k = 32'h49b40821;
      16: k = 32'hf61e2562; 17: k = 32'hc040b340; 18: k = 32'h265e5a51; 19: k = 32'he9b6c7aa;
      20: k = 32'hd62f105d; 21: k = 32'h02441453; 22: k = 32'hd8a1e681; 23: k = 32'he7d3fbc8;
      24: k = 32'h21e1cde6; 25: k = 32'hc33707d6; 26: k = 32'hf4d50d87; 27: k = 32'h455a14ed;
      28: k = 32'ha9e3e905; 29: k = 32'hfcefa3f8; 30: k = 32'h676f02d9; 31: k = 32'h8d2a4c8a;
      32: k = 32'hfffa3942; 33: k = 32'h8771f681; 34: k = 32'h6d9d6122; 35: k = 32'hfde5380c;
      36: k = 32'ha4beea44; 37: k = 32'h4bdecfa9; 38: k = 32'hf6bb4b60; 39: k = 32'hbebfbc70;
      40: k = 32'h289b7ec6; 41: k = 32'heaa127fa; 42: k = 32'hd4ef3085; 43: k = 32'h04881d05;
      44: k = 32'hd9d4d039; 45: k = 32'he6db99e5; 46: k = 32'h1fa27cf8; 47: k = 32'hc4ac5665;
      48: k = 32'hf4292244; 49: k = 32'h432aff97; 50: k = 32'hab9423a7; 51: k = 32'hfc93a039;
      52: k = 32'h655b59c3; 53: k = 32'h8f0ccc92; 54: k = 32'hffeff47d; 55: k = 32'h85845dd1;
      56: k = 32'h6fa87e4f; 57: k = 32'hfe2ce6e0; 58: k = 32'ha3014314; 59: k = 32'h4e0811a1;
      60: k = 32'hf7537e82; 61: k = 32'hbd3af235; 62: k = 32'h2ad7d2bb; 63: k = 32'heb86d391;
      default: k = '0;
    endcase
    return k;
  endfunction

  // left rotate amount of a round
  function automatic int md_rot(input int i);
    int r;
    case (((i / 16) * 4) + (i % 4))
      0: r = 7;   1: r = 12;  2: r = 17;  3: r = 22;
      4: r = 5;   5: r = 9;   6: r = 14;  7: r = 20;
      8: r = 4;   9: r = 11;  10: r = 16; 11: r = 23;
      12: r = 6;  13: r = 10; 14: r = 15; 15: r = 21;
      default: r = 0;
    endcase
    return r;
  endfunction

  // message word used by a round
  function automatic int md_word(input int i);
    int g;
    case (i / 16)
      0: g = i;
      1: g = (5 * i + 1) % 16;
      2: g = (3 * i + 5) % 16;
      default: g = (7 * i) % 16;
    endcase
    return g;
  endfunction

endpackage

// ----- rtl/mpcm_if.sv -----
// valid/ready channel interfaces for candidates and verdicts
interface mpcm_cand_if;
  import mpcm_pkg::*;
  logic             valid;
  logic             ready;
  logic [CandW-1:0] candidate_number;
  modport source (output valid, output candidate_number, input ready);
  modport sink (input valid, input candidate_number, output ready);
endinterface

interface mpcm_res_if;
  import mpcm_pkg::*;
  logic             valid;
  logic             ready;
  logic             match;
  logic [CandW-1:0] candidate_echo;
  modport source (output valid, output match, output candidate_echo, input ready);
  modport sink (input valid, input match, input candidate_echo, output ready);
endinterface

// ----- rtl/mpcm_digit.sv -----
// one decimal digit extraction stage, least significant digit first
module mpcm_digit #(
  parameter int PIN_DIGITS = mpcm_pkg::PinDigitsDef,
  parameter int DIGIT      = 0
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                adv,
  input  logic                                in_valid,
  input  logic [mpcm_pkg::CandW-1:0]          in_num,
  input  logic [mpcm_pkg::CandW-1:0]          in_cand,
  input  logic [PIN_DIGITS-1:0][3:0]          in_digits,
  output logic                                out_valid,
  output logic [mpcm_pkg::CandW-1:0]          out_num,
  output logic [mpcm_pkg::CandW-1:0]          out_cand,
  output logic [PIN_DIGITS-1:0][3:0]          out_digits
);
  import mpcm_pkg::*;

  logic [CandW+31:0]        prod;
  logic [CandW-1:0]         quot;
  logic [CandW-1:0]         times_ten;
  logic [3:0]               rem;
  logic [PIN_DIGITS-1:0][3:0] digits_next;

  // divide by ten through the reciprocal, exact below 2^32
  always_comb begin
    prod      = (CandW + 32)'(in_num) * (CandW + 32)'(32'hcccccccd);
    quot      = CandW'(prod >> 35);
    times_ten = (quot << 3) + (quot << 1);
    rem       = 4'(in_num - times_ten);
  end

  // insert this stage's digit into the digit vector
  always_comb begin
    digits_next        = in_digits;
    digits_next[DIGIT] = rem;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_num    <= quot;
      out_cand   <= in_cand;
      out_digits <= digits_next;
    end
  end

endmodule

// ----- rtl/mpcm_round.sv -----
// one md5 round as a pipeline stage
module mpcm_round #(
  parameter int ROUND = 0
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       adv,
  input  logic                       in_valid,
  input  mpcm_pkg::md_state_t        in_st,
  input  mpcm_pkg::md_block_t        in_blk,
  input  logic [mpcm_pkg::CandW-1:0] in_cand,
  output logic                       out_valid,
  output mpcm_pkg::md_state_t        out_st,
  output mpcm_pkg::md_block_t        out_blk,
  output logic [mpcm_pkg::CandW-1:0] out_cand
);
  import mpcm_pkg::*;

  localparam int          Grp  = ROUND / 16;
  localparam int          Widx = md_word(ROUND);
  localparam int          Rot  = md_rot(ROUND);
  localparam logic [31:0] Kc   = md_k(ROUND);

  logic [31:0] f;
  logic [31:0] sum;
  logic [31:0] rot;

  // round function of this group
  always_comb begin
    case (Grp)
      0: f = (in_st.b & in_st.c) | (~in_st.b & in_st.d);
      1: f = (in_st.d & in_st.b) | (~in_st.d & in_st.c);
      2: f = in_st.b ^ in_st.c ^ in_st.d;
      default: f = in_st.c ^ (in_st.b | ~in_st.d);
    endcase
    sum = in_st.a + f + Kc + in_blk[Widx];
    rot = (sum << Rot) | (sum >> (32 - Rot));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
  end

  // state rotates through a, b, c, d
  always_ff @(posedge clk) begin
    if (adv) begin
      out_st.a <= in_st.d;
      out_st.b <= in_st.b + rot;
      out_st.c <= in_st.b;
      out_st.d <= in_st.c;
      out_blk  <= in_blk;
      out_cand <= in_cand;
    end
  end

endmodule

// ----- rtl/mpcm_final.sv -----
// chaining add, digest prefix compare and output register
module mpcm_final (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       adv,
  input  logic                       in_valid,
  input  mpcm_pkg::md_state_t        in_st,
  input  logic [mpcm_pkg::CandW-1:0] in_cand,
  input  logic [127:0]               target,
  input  logic [5:0]                 prefix,
  output logic                       out_valid,
  output logic                       out_match,
  output logic [mpcm_pkg::CandW-1:0] out_cand
);
  import mpcm_pkg::*;

  logic [31:0]  ha, hb, hc, hd;
  logic [127:0] digest;
  logic [5:0]   want;
  logic         ok;

  // digest in printed byte order, byte 0 in the top bits
  always_comb begin
    ha     = in_st.a + MdIv.a;
    hb     = in_st.b + MdIv.b;
    hc     = in_st.c + MdIv.c;
    hd     = in_st.d + MdIv.d;
    digest = {ha[7:0], ha[15:8], ha[23:16], ha[31:24],
              hb[7:0], hb[15:8], hb[23:16], hb[31:24],
              hc[7:0], hc[15:8], hc[23:16], hc[31:24],
              hd[7:0], hd[15:8], hd[23:16], hd[31:24]};
    want   = (prefix > 6'd32) ? 6'd32 : prefix;
    ok     = 1'b1;
    for (int k = 0; k < 32; k++) begin
      if ((6'(k) < want) && (digest[127-4*k -: 4] != target[127-4*k -: 4])) begin
        ok = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_match <= ok;
      out_cand  <= in_cand;
    end
  end

endmodule

// ----- rtl/md5_pin_candidate_matcher.sv -----
// top level of the md5 pin candidate matcher
//
// cand_in carries one candidate_number per transaction; res_out returns one
// transaction per candidate, in order, with match and candidate_echo.
// the candidate is written as PIN_DIGITS ascii digits with leading zeros,
// hashed with md5 and the leading prefix_digits nibbles of the digest are
// compared with the target digest set over the apb port.
// the pipeline has one stage per decimal digit, one stage per md5 round and
// one output stage for the final add and the compare. throughput is one
// candidate per cycle while res_out is not stalled.
// the pipeline advances as a whole; when res_out is stalled with a result
// held, cand_in.ready drops and every stage holds its contents.
// reset clears all valid bits and the registers: target zero, prefix 32.
// registers sit at byte addresses 0, 8 and 16; write only while idle.
module md5_pin_candidate_matcher #(
  parameter int PIN_DIGITS = mpcm_pkg::PinDigitsDef
) (
  input  logic                       clk,
  input  logic                       rst,
  mpcm_cand_if.sink                  cand_in,
  mpcm_res_if.source                 res_out,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [mpcm_pkg::AddrW-1:0] paddr,
  input  logic [63:0]                pwdata,
  output logic [63:0]                prdata,
  output logic                       pready
);
  import mpcm_pkg::*;

  logic [63:0] target_digest_high;
  logic [63:0] target_digest_low;
  logic [5:0]  prefix_digits;
  reg_idx_t    reg_sel;
  logic        adv;

  // configuration registers
  assign pready  = 1'b1;
  assign reg_sel = reg_idx_t'(paddr[AddrW-1:3]);

  always_ff @(posedge clk) begin
    if (rst) begin
      target_digest_high <= '0;
      target_digest_low  <= '0;
      prefix_digits      <= PrefixReset;
    end else if (psel && penable && pwrite) begin
      case (reg_sel)
        REG_TGT_HIGH: target_digest_high <= pwdata;
        REG_TGT_LOW:  target_digest_low  <= pwdata;
        REG_PREFIX:   prefix_digits      <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_TGT_HIGH: prdata = target_digest_high;
      REG_TGT_LOW:  prdata = target_digest_low;
      REG_PREFIX:   prdata = {58'b0, prefix_digits};
      default:      prdata = '0;
    endcase
  end

  // whole pipeline moves unless a result is held at the output
  assign adv           = !res_out.valid || res_out.ready;
  assign cand_in.ready = adv;

  // decimal digit stages
  logic [PIN_DIGITS:0]                       dv;
  logic [PIN_DIGITS:0][CandW-1:0]            dn;
  logic [PIN_DIGITS:0][CandW-1:0]            dc;
  logic [PIN_DIGITS:0][PIN_DIGITS-1:0][3:0]  dd;

  assign dv[0] = cand_in.valid;
  assign dn[0] = cand_in.candidate_number;
  assign dc[0] = cand_in.candidate_number;
  assign dd[0] = '0;

  for (genvar j = 0; j < PIN_DIGITS; j++) begin : g_digit
    mpcm_digit #(.PIN_DIGITS(PIN_DIGITS), .DIGIT(j)) u_digit (
      .clk        (clk),
      .rst        (rst),
      .adv        (adv),
      .in_valid   (dv[j]),
      .in_num     (dn[j]),
      .in_cand    (dc[j]),
      .in_digits  (dd[j]),
      .out_valid  (dv[j+1]),
      .out_num    (dn[j+1]),
      .out_cand   (dc[j+1]),
      .out_digits (dd[j+1])
    );
  end

  // padded single message block
  logic [63:0][7:0] msg_bytes;
  md_block_t        blk;

  always_comb begin
    for (int i = 0; i < 64; i++) begin
      if (i < PIN_DIGITS) begin
        msg_bytes[i] = {4'h3, dd[PIN_DIGITS][PIN_DIGITS-1-i]};
      end else if (i == PIN_DIGITS) begin
        msg_bytes[i] = 8'h80;
      end else if (i == 56) begin
        msg_bytes[i] = 8'(PIN_DIGITS * 8);
      end else begin
        msg_bytes[i] = 8'h00;
      end
    end
    for (int w = 0; w < 16; w++) begin
      blk[w] = {msg_bytes[4*w+3], msg_bytes[4*w+2], msg_bytes[4*w+1], msg_bytes[4*w]};
    end
  end

  // md5 round stages
  logic      [Rounds:0]            rv;
  md_state_t [Rounds:0]            rs;
  md_block_t [Rounds:0]            rb;
  logic      [Rounds:0][CandW-1:0] rc;

  assign rv[0] = dv[PIN_DIGITS];
  assign rs[0] = MdIv;
  assign rb[0] = blk;
  assign rc[0] = dc[PIN_DIGITS];

  for (genvar r = 0; r < Rounds; r++) begin : g_round
    mpcm_round #(.ROUND(r)) u_round (
      .clk       (clk),
      .rst       (rst),
      .adv       (adv),
      .in_valid  (rv[r]),
      .in_st     (rs[r]),
      .in_blk    (rb[r]),
      .in_cand   (rc[r]),
      .out_valid (rv[r+1]),
      .out_st    (rs[r+1]),
      .out_blk   (rb[r+1]),
      .out_cand  (rc[r+1])
    );
  end

  // finish, compare and hold the result
  mpcm_final u_final (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (rv[Rounds]),
    .in_st     (rs[Rounds]),
    .in_cand   (rc[Rounds]),
    .target    ({target_digest_high, target_digest_low}),
    .prefix    (prefix_digits),
    .out_valid (res_out.valid),
    .out_match (res_out.match),
    .out_cand  (res_out.candidate_echo)
  );

endmodule

// ----- rtl/mpcm_checker.sv -----
// port level checker for the matcher and its bind
`include "md5_pin_candidate_matcher_macros.svh"

module mpcm_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic                       out_match,
  input logic [mpcm_pkg::CandW-1:0] out_echo
);

  // no result right after reset
  `MPCM_ASSERT_ALWAYS(a_rst_empty, rst |=> !out_valid, "result valid after reset")

  // input side opens exactly when the output register can move
  `MPCM_ASSERT(a_ready_link, in_ready == (!out_valid || out_ready), "input ready mismatch")

  // a stalled result keeps its verdict and candidate
  `MPCM_ASSERT(a_hold, out_valid && !out_ready |=> out_valid && $stable(out_echo) && $stable(out_match), "stalled result changed")

endmodule

bind md5_pin_candidate_matcher mpcm_checker u_mpcm_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (cand_in.ready),
  .out_valid (res_out.valid),
  .out_ready (res_out.ready),
  .out_match (res_out.match),
  .out_echo  (res_out.candidate_echo)
);
